// ===== src/pcmq_pkg.sv =====
`default_nettype none

package pcmq_pkg;

    localparam int QUEUE_DEPTH      = 4;
    localparam int MAX_WRITE_FRAMES = 2048;

    localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * QUEUE_DEPTH);

    localparam int CAP_W    = 17;
    localparam int CHAN_W   = 2;
    localparam int GAIN_W   = 16;
    localparam int FRAMES_W = 16;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 12;
    localparam int SCNT_W   = 13;
    localparam int TOTAL_W  = 48;
    localparam int UNDER_W  = 31;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME   = 2'd2;

    localparam logic [CAP_W-1:0]  CAPACITY_RST = 17'd4096;
    localparam logic [CHAN_W-1:0] CHANNELS_RST = 2'd1;
    localparam logic [GAIN_W-1:0] VOLUME_RST   = 16'd32768;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_DONE   = 3'd2,
        OP_FLUSH  = 3'd3,
        OP_PAUSE  = 3'd4,
        OP_RESUME = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [2:0]                 opcode;
        logic [FRAMES_W-1:0]        frame_count;
        logic signed [SAMPLE_W-1:0] sample_in;
    } t_in_word;

    typedef struct packed {
        logic                       status;
        logic [ACC_W-1:0]           grant_frames;
        logic [SCNT_W-1:0]          sample_count;
        logic signed [SAMPLE_W-1:0] scaled_sample;
        logic [CAP_W-1:0]           queued_total;
        logic [TOTAL_W-1:0]         consumed_total;
        logic [TOTAL_W-1:0]         written_total;
        logic [UNDER_W-1:0]         underrun_total;
        logic                       is_paused;
    } t_out_word;

    typedef struct packed {
        logic [CAP_W-1:0]  queue_capacity;
        logic [CHAN_W-1:0] chan_per_frame;
        logic [GAIN_W-1:0] volume_gain;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/pcmq_cfg.sv =====
`default_nettype none

module pcmq_cfg (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [pcmq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [pcmq_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output pcmq_pkg::t_cfg                o_cfg
);
    import pcmq_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.queue_capacity <= CAPACITY_RST;
            r_cfg.chan_per_frame <= CHANNELS_RST;
            r_cfg.volume_gain    <= VOLUME_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAPACITY: r_cfg.queue_capacity <= i_cfg_data[CAP_W-1:0];
                CFG_CHANNELS: r_cfg.chan_per_frame <= i_cfg_data[CHAN_W-1:0];
                CFG_VOLUME:   r_cfg.volume_gain    <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/pcmq_scale.sv =====
`default_nettype none

module pcmq_scale (
    input  wire signed [pcmq_pkg::SAMPLE_W-1:0] i_sample,
    input  wire        [pcmq_pkg::GAIN_W-1:0]   i_gain,
    output logic signed [pcmq_pkg::SAMPLE_W-1:0] o_scaled
);
    import pcmq_pkg::*;

    logic signed [SAMPLE_W+GAIN_W:0]   product;
    logic signed [SAMPLE_W+GAIN_W:0]   biased;
    logic signed [SAMPLE_W+GAIN_W-15:0] quotient;

    always_comb begin
        product = (SAMPLE_W+GAIN_W+1)'(i_sample) *
                  (SAMPLE_W+GAIN_W+1)'($signed({1'b0, i_gain}));
        // Adding 2^15-1 before the shift makes negative products round toward zero.
        biased  = product[SAMPLE_W+GAIN_W] ? product + 33'sd32767 : product;
        quotient = biased[SAMPLE_W+GAIN_W:15];
        if (quotient > 18'sd32767) begin
            o_scaled = 16'sh7FFF;
        end else if (quotient < -18'sd32768) begin
            o_scaled = 16'sh8000;
        end else begin
            o_scaled = quotient[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/pcmq_acct.sv =====
`default_nettype none

module pcmq_acct (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    input  pcmq_pkg::t_in_word                i_item,
    input  pcmq_pkg::t_cfg                    i_cfg,
    input  wire signed [pcmq_pkg::SAMPLE_W-1:0] i_scaled,
    output pcmq_pkg::t_out_word               o_result
);
    import pcmq_pkg::*;

    logic [ACC_W-1:0]   r_buf [QUEUE_DEPTH];
    logic [CNT_W-1:0]   r_count,    n_count;
    logic [HEAD_W-1:0]  r_head,     n_head;
    logic [CAP_W-1:0]   r_queued,   n_queued;
    logic [TOTAL_W-1:0] r_written,  n_written;
    logic [TOTAL_W-1:0] r_consumed, n_consumed;
    logic [UNDER_W-1:0] r_under,    n_under;
    logic               r_paused,   n_paused;
    logic               r_starve,   n_starve;

    logic [CAP_W-1:0]    room;
    logic [FRAMES_W-1:0] req_lim;
    logic [CAP_W-1:0]    grant;
    logic [ACC_W-1:0]    grant_w;
    logic [SUM_W-1:0]    tail_sum;
    logic [HEAD_W-1:0]   tail;
    logic [ACC_W-1:0]    head_frames;
    logic [ACC_W+CHAN_W-1:0] samples;
    logic                push;

    always_comb begin
        room     = (i_cfg.queue_capacity > r_queued) ? i_cfg.queue_capacity - r_queued : '0;
        req_lim  = (i_item.frame_count < FRAMES_W'(MAX_WRITE_FRAMES)) ?
                   i_item.frame_count : FRAMES_W'(MAX_WRITE_FRAMES);
        grant    = (room < CAP_W'(req_lim)) ? room : CAP_W'(req_lim);
        grant_w  = grant[ACC_W-1:0];
        samples  = {{CHAN_W{1'b0}}, grant_w} * {{ACC_W{1'b0}}, i_cfg.chan_per_frame};
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
        head_frames = r_buf[r_head];
        push     = 1'b0;

        n_count    = r_count;
        n_head     = r_head;
        n_queued   = r_queued;
        n_written  = r_written;
        n_consumed = r_consumed;
        n_under    = r_under;
        n_paused   = r_paused;
        n_starve   = r_starve;

        o_result                 = '0;

        case (i_item.opcode)
            OP_WRITE: begin
                if (i_item.frame_count == '0) begin
                    o_result.status = 1'b1;
                end else if (r_count != CNT_W'(QUEUE_DEPTH) && grant != '0) begin
                    push = 1'b1;
                    if (r_starve && !r_paused) begin
                        n_starve = 1'b0;
                        if (r_under != '1) begin
                            n_under = r_under + 1'b1;
                        end
                    end
                    n_count   = r_count + 1'b1;
                    n_queued  = r_queued + grant;
                    n_written = r_written + TOTAL_W'(grant_w);
                    o_result.grant_frames = grant_w;
                    o_result.sample_count = samples[SCNT_W-1:0];
                end
            end
            OP_SAMPLE: begin
                o_result.scaled_sample = i_scaled;
            end
            OP_DONE: begin
                if (r_count == '0) begin
                    if (r_under != '1) begin
                        n_under = r_under + 1'b1;
                    end
                end else begin
                    n_consumed = r_consumed + TOTAL_W'(head_frames);
                    n_queued   = (r_queued >= CAP_W'(head_frames)) ?
                                 r_queued - CAP_W'(head_frames) : '0;
                    n_head     = (r_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count    = r_count - 1'b1;
                    n_starve   = (r_count == CNT_W'(1));
                end
            end
            OP_FLUSH: begin
                n_count  = '0;
                n_head   = '0;
                n_queued = '0;
                n_starve = 1'b0;
            end
            OP_PAUSE:  n_paused = 1'b1;
            OP_RESUME: n_paused = 1'b0;
            default: begin
            end
        endcase

        o_result.queued_total   = n_queued;
        o_result.consumed_total = n_consumed;
        o_result.written_total  = n_written;
        o_result.underrun_total = n_under;
        o_result.is_paused      = n_paused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_head     <= '0;
            r_queued   <= '0;
            r_written  <= '0;
            r_consumed <= '0;
            r_under    <= '0;
            r_paused   <= 1'b0;
            r_starve   <= 1'b0;
        end else if (i_valid) begin
            r_count    <= n_count;
            r_head     <= n_head;
            r_queued   <= n_queued;
            r_written  <= n_written;
            r_consumed <= n_consumed;
            r_under    <= n_under;
            r_paused   <= n_paused;
            r_starve   <= n_starve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && push) begin
            r_buf[tail] <= grant_w;
        end
    end

endmodule

`default_nettype wire

// ===== src/pcm_output_queue_accounting.sv =====
// Channel   Handshake                         Payload
// input     start, busy (accept: start&!busy)  i_in  (t_in_word)
// result    o_done strobe, one cycle           o_out (t_out_word)
// config    i_cfg_valid, o_cfg_ready           i_cfg_index, i_cfg_data
//
// A word is registered on acceptance and worked through the queue books and
// the volume multiplier; its result is registered in r_out after it leaves r_in,
// and o_done marks that registered result while o_out holds it.
// A new word may be accepted every cycle, so busy is always low.
// Reset is synchronous and active low; it clears the queue and all totals.
// The receiver cannot stall, and configuration writes are taken at once.
`default_nettype none

module pcm_output_queue_accounting (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  pcmq_pkg::t_in_word             i_in,
    output logic                           o_done,
    output pcmq_pkg::t_out_word            o_out,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [pcmq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [pcmq_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pcmq_pkg::*;

    logic                       r_in_valid;
    t_in_word                   r_in;
    logic                       r_done;
    t_out_word                  r_out;
    t_cfg                       cfg;
    logic signed [SAMPLE_W-1:0] scaled;
    t_out_word                  n_out;

    assign busy   = 1'b0;
    assign o_done = r_done;
    assign o_out  = r_out;

    pcmq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pcmq_scale u_scale (
        .i_sample (r_in.sample_in),
        .i_gain   (cfg.volume_gain),
        .o_scaled (scaled)
    );

    pcmq_acct u_acct (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .i_scaled (scaled),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_done     <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_in;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted word produced no result");

    a_invalid_grants_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status) |-> (o_out.grant_frames == '0 && o_out.sample_count == '0))
        else $error("invalid write request granted frames");

    a_grant_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.grant_frames <= ACC_W'(MAX_WRITE_FRAMES)))
        else $error("grant exceeds per-write limit");

    a_underrun_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done)) |-> (o_out.underrun_total >= $past(o_out.underrun_total)))
        else $error("underrun count went down");

endmodule

`default_nettype wire
